// ===== src/oahs_pkg.sv =====
// shared constants and types of the open-addressed hash set
`timescale 1ns / 1ps

package oahs_pkg;

  localparam int KEY_W         = 31;
  localparam int ACT_W         = 2;
  localparam int STATUS_W      = 2;
  localparam int SLOT_W        = 6;
  localparam int SIZE_W        = 7;
  localparam int DEPTH_DEFAULT = 64;
  localparam int MOD_DIGITS    = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_SEARCH = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY    = 2'd0,
    MARK_OCCUPIED = 2'd1,
    MARK_DELETED  = 2'd2
  } mark_t;

endpackage

// ===== src/oahs_if.sv =====
// request, response and configuration channel interfaces
`timescale 1ns / 1ps

interface oahs_req_if import oahs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output action, output key, input ready);
  modport sink (input valid, input action, input key, output ready);
endinterface

interface oahs_rsp_if import oahs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink (input valid, input status, input slot, output ready);
endinterface

interface oahs_cfg_if import oahs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] table_size;

  modport source (output valid, output table_size, input ready);
  modport sink (input valid, input table_size, output ready);
endinterface

// ===== src/open_address_hash_set_top.sv =====
// open-addressed hash set of 31-bit keys with linear probing and tombstones
//
// req carries action and key, rsp returns status and slot, one response per
// request, in order. cfg writes table_size at any time the block is idle;
// values 0 and above TABLE_DEPTH act as 1 and TABLE_DEPTH.
// search, add and remove: accept, then key modulo table size in the
// remainder unit, one memory read, then a probe walk of one bucket a cycle
// (up to table_size buckets), then the response register. clear sweeps all
// TABLE_DEPTH marks, one bucket a cycle. The single memory read port and
// the probe walk set the rate; one request is in work at a time.
// After reset the block sweeps the whole mark memory with req.ready low;
// cfg is taken throughout.
// The response sits in an output register; while rsp.ready is low the next
// request is still accepted and worked, and its result waits until the
// register is free.
`timescale 1ns / 1ps

module open_address_hash_set_top import oahs_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  oahs_cfg_if.sink    cfg,
  oahs_req_if.sink    req,
  oahs_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CW    = (IDX_W + 1 > SIZE_W) ? IDX_W + 1 : SIZE_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_MOD,
    S_RD,
    S_PROBE,
    S_CLEAR,
    S_OUT
  } state_t;

  state_t              state;
  logic [SIZE_W-1:0]   size_cfg;
  logic [SIZE_W-1:0]   size_eff;
  logic [SIZE_W-1:0]   size_r;
  action_t             act_r;
  logic [KEY_W-1:0]    key_r;
  logic [IDX_W-1:0]    pos;
  logic [IDX_W-1:0]    pos_nx;
  logic [CW-1:0]       pos_inc;
  logic [SIZE_W-1:0]   n;
  logic                ff_vld;
  logic [IDX_W-1:0]    ff_pos;
  logic [IDX_W-1:0]    cnt;
  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  status_t             end_status;
  logic [SLOT_W-1:0]   end_slot;
  logic                rsp_valid;
  status_t             rsp_status;
  logic [SLOT_W-1:0]   rsp_slot;

  logic                req_fire;
  logic                mod_start;
  logic                mod_done;
  logic [SIZE_W-1:0]   mod_rem;

  logic [IDX_W-1:0]    rd_addr;
  mark_t               rd_mark;
  logic [KEY_W-1:0]    rd_key;
  logic                mark_we;
  logic                key_we;
  logic [IDX_W-1:0]    wr_addr;
  mark_t               wr_mark;

  logic                hit;
  logic                empty;
  logic                last;
  logic                free;
  logic                free_any;
  logic [IDX_W-1:0]    free_pos;
  logic                probe_end;

  assign cfg.ready = !rst;
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign mod_start = req_fire && (req.action != ACT_CLEAR);

  always_comb begin
    if (size_cfg == '0) begin
      size_eff = SIZE_W'(1);
    end else if (int'(size_cfg) > TABLE_DEPTH) begin
      size_eff = SIZE_W'(TABLE_DEPTH);
    end else begin
      size_eff = size_cfg;
    end
  end

  assign pos_inc = CW'(pos) + 1'b1;
  assign pos_nx  = (pos_inc == CW'(size_r)) ? '0 : IDX_W'(pos_inc);
  assign rd_addr = (state == S_PROBE) ? pos_nx : pos;

  assign hit       = (rd_mark == MARK_OCCUPIED) && (rd_key == key_r);
  assign empty     = (rd_mark == MARK_EMPTY);
  assign last      = (n == size_r - 1'b1);
  assign free      = (rd_mark != MARK_OCCUPIED);
  assign free_any  = ff_vld || free;
  assign free_pos  = ff_vld ? ff_pos : pos;
  assign probe_end = (state == S_PROBE) && (hit || empty || last);

  always_comb begin
    if (hit) begin
      end_status = (act_r == ACT_ADD) ? ST_PRESENT : ST_OK;
      end_slot   = SLOT_W'(pos);
    end else if (act_r == ACT_ADD && free_any) begin
      end_status = ST_OK;
      end_slot   = SLOT_W'(free_pos);
    end else if (act_r == ACT_ADD) begin
      end_status = ST_FULL;
      end_slot   = '0;
    end else begin
      end_status = ST_ABSENT;
      end_slot   = '0;
    end
  end

  always_comb begin
    mark_we = 1'b0;
    key_we  = 1'b0;
    wr_addr = pos;
    wr_mark = MARK_EMPTY;
    unique case (state)
      S_INIT, S_CLEAR: begin
        mark_we = 1'b1;
        wr_addr = cnt;
      end
      S_PROBE: begin
        if (probe_end && act_r == ACT_ADD && !hit && free_any) begin
          mark_we = 1'b1;
          key_we  = 1'b1;
          wr_addr = free_pos;
          wr_mark = MARK_OCCUPIED;
        end else if (probe_end && act_r == ACT_REMOVE && hit) begin
          mark_we = 1'b1;
          wr_mark = MARK_DELETED;
        end
      end
      default: begin
      end
    endcase
  end

  oahs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (req.key),
    .divisor  (size_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  oahs_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_mark (rd_mark),
    .rd_key  (rd_key),
    .mark_we (mark_we),
    .key_we  (key_we),
    .wr_addr (wr_addr),
    .wr_mark (wr_mark),
    .wr_key  (key_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      cnt       <= '0;
      size_cfg  <= SIZE_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        size_cfg <= cfg.table_size;
      end
      if (rsp_valid && rsp.ready && state != S_OUT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            act_r  <= action_t'(req.action);
            key_r  <= req.key;
            size_r <= size_eff;
            cnt    <= '0;
            state  <= (req.action == ACT_CLEAR) ? S_CLEAR : S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            pos    <= IDX_W'(mod_rem);
            n      <= '0;
            ff_vld <= 1'b0;
            state  <= S_RD;
          end
        end
        S_RD: begin
          state <= S_PROBE;
        end
        S_PROBE: begin
          if (free && !ff_vld) begin
            ff_vld <= 1'b1;
            ff_pos <= pos;
          end
          if (probe_end) begin
            res_status <= end_status;
            res_slot   <= end_slot;
            state      <= S_OUT;
          end else begin
            pos <= pos_nx;
            n   <= n + 1'b1;
          end
        end
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            res_status <= ST_OK;
            res_slot   <= '0;
            state      <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= res_status;
            rsp_slot   <= res_slot;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.slot   = rsp_slot;

`ifndef SYNTH
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mark_we)
    else $error("mark memory written while idle");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PROBE) |-> (n < size_r))
    else $error("probe count reached table size");

  a_mod_done: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_MOD))
    else $error("remainder finished outside hashing state");

  a_rsp_load: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !$past(rsp_valid)) |-> $past(state == S_OUT))
    else $error("response raised without a finished request");
`endif

endmodule

// ===== src/oahs_mod.sv =====
// iterative remainder unit, key modulo table size, four bits per cycle
`timescale 1ns / 1ps

module oahs_mod import oahs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KEY_W-1:0]  dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [SIZE_W-1:0] rem
);

  localparam int STEPS = (KEY_W + MOD_DIGITS - 1) / MOD_DIGITS;
  localparam int PAD_W = STEPS * MOD_DIGITS;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [PAD_W-1:0]  sh;
  logic [SIZE_W-1:0] r;
  logic [SIZE_W-1:0] div_r;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic              done_q;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W-1:0] acc;

  always_comb begin
    acc   = r;
    trial = '0;
    for (int i = 0; i < MOD_DIGITS; i++) begin
      trial = {acc, sh[PAD_W-1-i]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      acc = trial[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        sh    <= PAD_W'(dividend);
        r     <= '0;
        div_r <= divisor;
        cnt   <= CNT_W'(STEPS - 1);
        run   <= 1'b1;
      end else if (run) begin
        sh  <= sh << MOD_DIGITS;
        r   <= acc;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run    <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done = done_q;
  assign rem  = r;

endmodule

// ===== src/oahs_store.sv =====
// bucket mark and key memories, one write and one registered read port
`timescale 1ns / 1ps

module oahs_store import oahs_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT,
  parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output mark_t            rd_mark,
  output logic [KEY_W-1:0] rd_key,
  input  logic             mark_we,
  input  logic             key_we,
  input  logic [IDX_W-1:0] wr_addr,
  input  mark_t            wr_mark,
  input  logic [KEY_W-1:0] wr_key
);

  mark_t            marks [TABLE_DEPTH];
  logic [KEY_W-1:0] keys  [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (mark_we) begin
      marks[wr_addr] <= wr_mark;
    end
    rd_mark <= marks[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      keys[wr_addr] <= wr_key;
    end
    rd_key <= keys[rd_addr];
  end

endmodule
